// ===== hdl/ktm_pkg.sv =====
// ----------------------------------------------------------------------------
// ktm_pkg
// shared types, field widths, codes and reset values of the keepalive monitor
// ----------------------------------------------------------------------------
package ktm_pkg;

    // fixed field widths of the channels
    localparam int KIND_BITS       = 3;
    localparam int SLOT_FIELD_BITS = 6;
    localparam int TIME_FIELD_BITS = 48;
    localparam int PING_BITS       = 32;
    localparam int CFG_BITS        = 32;
    localparam int CFG_IDX_BITS    = 2;

    // default sizing
    localparam int NUM_SLOTS_DEFAULT = 64;
    localparam int TIME_BITS_DEFAULT = 48;

    // register reset values
    localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 32'd15000;
    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET  = 32'd30000;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_JOIN     = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_LEAVE    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SENT     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_RESPONSE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_UPDATE   = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_SCAN     = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT  = 2'd1;

    // age test results of one slot
    typedef struct packed {
        logic need;
        logic expired;
    } t_flags;

    // one result beat
    typedef struct packed {
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic                       known;
        logic                       matched;
        logic                       needs_keepalive;
        logic                       timed_out;
        logic [PING_BITS-1:0]       ping_ms;
        logic [TIME_FIELD_BITS-1:0] sent_at;
        logic [TIME_FIELD_BITS-1:0] received_at;
        logic                       last;
    } t_result;

endpackage

// ===== hdl/ktm_if.sv =====
// ----------------------------------------------------------------------------
// ktm_if
// valid/ready channels of the keepalive monitor: items, results, registers
// ----------------------------------------------------------------------------
interface ktm_in_if;
    logic                                valid;
    logic                                ready;
    logic [ktm_pkg::KIND_BITS-1:0]       kind;
    logic [ktm_pkg::SLOT_FIELD_BITS-1:0] player;
    logic [ktm_pkg::TIME_FIELD_BITS-1:0] stamp;
    logic [ktm_pkg::TIME_FIELD_BITS-1:0] now;

    modport source (output valid, kind, player, stamp, now, input ready);
    modport sink   (input valid, kind, player, stamp, now, output ready);
endinterface

interface ktm_out_if;
    logic                                valid;
    logic                                ready;
    logic [ktm_pkg::SLOT_FIELD_BITS-1:0] slot;
    logic                                known;
    logic                                matched;
    logic                                needs_keepalive;
    logic                                timed_out;
    logic [ktm_pkg::PING_BITS-1:0]       ping_ms;
    logic [ktm_pkg::TIME_FIELD_BITS-1:0] sent_at;
    logic [ktm_pkg::TIME_FIELD_BITS-1:0] received_at;
    logic                                last;

    modport source (output valid, slot, known, matched, needs_keepalive, timed_out,
                    ping_ms, sent_at, received_at, last, input ready);
    modport sink   (input valid, slot, known, matched, needs_keepalive, timed_out,
                    ping_ms, sent_at, received_at, last, output ready);
endinterface

interface ktm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ktm_pkg::CFG_IDX_BITS-1:0] index;
    logic [ktm_pkg::CFG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/keepalive_timeout_monitor.sv =====
// ----------------------------------------------------------------------------
// keepalive_timeout_monitor
// per-connection keepalive table: join, leave, sent, response, update, scan
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | beat taken when
//  --------+-----+-------------------------------------------+----------------
//  i_in    | in  | kind, player, stamp, now                  | valid & ready
//  o_res   | out | slot, known, matched, needs_keepalive,     | valid & ready
//          |     | timed_out, ping_ms, sent_at, received_at, |
//          |     | last                                      |
//  i_cfg   | in  | index, data (0 interval, 1 timeout)       | valid & ready
//
//  per-slot item: the accept cycle issues the table read, then S_EXEC
//    does the read-modify-write and loads the result register
//  scan: one table read and one test per slot
//    through the single read port of the table memory
//  reset: only slot valid flops, fsm, registers and result valid flags are
//    cleared; no memory clearing pass, join writes every field of its entry
//  a full result register stalls the fsm; i_in stays not ready meanwhile;
//    i_cfg is taken only while idle, ahead of a waiting item, never in reset
//
module keepalive_timeout_monitor #(
    parameter int NUM_SLOTS = ktm_pkg::NUM_SLOTS_DEFAULT,
    parameter int TIME_BITS = ktm_pkg::TIME_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ktm_in_if.sink      i_in,
    ktm_out_if.source   o_res,
    ktm_cfg_if.sink     i_cfg
);

    localparam int TF         = ktm_pkg::TIME_FIELD_BITS;
    localparam int PB         = ktm_pkg::PING_BITS;
    localparam int SF         = ktm_pkg::SLOT_FIELD_BITS;
    // stored stamps never exceed the field width
    localparam int STAMP_BITS = (TIME_BITS < TF) ? TIME_BITS : TF;
    localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_BITS = 2 * STAMP_BITS + PB;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END
    } t_state;

    // fsm and captured item
    t_state                         r_state, n_state;
    logic [ktm_pkg::KIND_BITS-1:0]  r_kind;
    logic [SF-1:0]                  r_player;
    logic [STAMP_BITS-1:0]          r_stamp;
    logic [STAMP_BITS-1:0]          r_now;
    logic [SLOT_BITS-1:0]           r_idx, n_idx;

    // slot valid flops
    logic [NUM_SLOTS-1:0]           r_valid, n_valid;

    // registers
    logic [ktm_pkg::CFG_BITS-1:0]   r_interval, n_interval;
    logic [ktm_pkg::CFG_BITS-1:0]   r_timeout, n_timeout;

    // result register and held scan hit
    ktm_pkg::t_result               r_out, n_out;
    logic                           r_out_valid, n_out_valid;
    ktm_pkg::t_result               r_pend, n_pend;
    logic                           r_pend_valid, n_pend_valid;

    // table memory
    logic                           mem_we;
    logic [SLOT_BITS-1:0]           mem_waddr;
    logic [ENTRY_BITS-1:0]          mem_wdata;
    logic                           mem_re;
    logic [SLOT_BITS-1:0]           mem_raddr;
    logic [ENTRY_BITS-1:0]          mem_rdata;

    logic [STAMP_BITS-1:0]          rd_sent;
    logic [STAMP_BITS-1:0]          rd_recv;
    logic [PB-1:0]                  rd_ping;

    // item handling
    logic                           in_take;
    logic                           out_free;
    logic [SLOT_BITS-1:0]           p_idx;
    logic                           p_in_range;
    logic                           p_live;
    logic                           live_after;
    logic                           matched;
    logic                           do_write;
    logic [STAMP_BITS-1:0]          new_sent;
    logic [STAMP_BITS-1:0]          new_recv;
    logic [PB-1:0]                  new_ping;

    // shared age tests
    logic [STAMP_BITS-1:0]          ev_sent;
    logic [STAMP_BITS-1:0]          ev_recv;
    ktm_pkg::t_flags                ev_flags;

    logic                           scan_hit;
    ktm_pkg::t_result               exec_res;
    ktm_pkg::t_result               scan_res;

    ktm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ktm_eval #(
        .TIME_BITS  (TIME_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_eval (
        .i_now      (r_now),
        .i_sent     (ev_sent),
        .i_recv     (ev_recv),
        .i_interval (r_interval),
        .i_timeout  (r_timeout),
        .o_flags    (ev_flags)
    );

    // entry layout: ping | received | sent
    assign rd_sent = mem_rdata[STAMP_BITS-1:0];
    assign rd_recv = mem_rdata[2*STAMP_BITS-1:STAMP_BITS];
    assign rd_ping = mem_rdata[ENTRY_BITS-1:2*STAMP_BITS];

    // handshakes, a register beat goes ahead of a waiting item
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = i_rst_n && (r_state == S_IDLE);
    assign in_take     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    // addressed slot of the held item
    assign p_idx      = r_player[SLOT_BITS-1:0];
    assign p_in_range = ({1'b0, r_player} < (SF + 1)'(NUM_SLOTS));
    assign p_live     = p_in_range && r_valid[p_idx];

    // read-modify-write of one entry
    always_comb begin
        new_sent   = rd_sent;
        new_recv   = rd_recv;
        new_ping   = rd_ping;
        matched    = 1'b0;
        do_write   = 1'b0;
        live_after = p_live;
        case (r_kind)
            ktm_pkg::KIND_JOIN: begin
                // a rejoin clears the slot again
                new_sent   = '0;
                new_recv   = '0;
                new_ping   = '0;
                do_write   = p_in_range;
                live_after = p_in_range;
            end
            ktm_pkg::KIND_LEAVE: begin
                live_after = 1'b0;
            end
            ktm_pkg::KIND_SENT: begin
                new_sent = r_stamp;
                do_write = p_live;
            end
            ktm_pkg::KIND_RESPONSE: begin
                if (p_live && (rd_sent == r_stamp)) begin
                    matched  = 1'b1;
                    new_recv = r_now;
                    new_ping = r_now[PB-1:0] - r_stamp[PB-1:0];
                    do_write = 1'b1;
                end
            end
            ktm_pkg::KIND_UPDATE: begin
                new_recv = r_stamp;
                do_write = p_live;
            end
            default: begin
            end
        endcase
    end

    // the age unit sees the updated entry for an item, the stored one in a scan
    assign ev_sent = (r_state == S_EXEC) ? new_sent : rd_sent;
    assign ev_recv = (r_state == S_EXEC) ? new_recv : rd_recv;

    // status of the addressed slot, all zero but slot and last when not live
    always_comb begin
        exec_res      = '0;
        exec_res.slot = r_player;
        exec_res.last = 1'b1;
        if (live_after) begin
            exec_res.known           = 1'b1;
            exec_res.matched         = matched;
            exec_res.needs_keepalive = ev_flags.need;
            exec_res.timed_out       = ev_flags.expired;
            exec_res.ping_ms         = new_ping;
            exec_res.sent_at         = TF'(new_sent);
            exec_res.received_at     = TF'(new_recv);
        end
    end

    // scan test: timeout only counts once something was received
    assign scan_hit = r_valid[r_idx]
                   && (ev_flags.need || ((rd_recv != '0) && ev_flags.expired));

    always_comb begin
        scan_res                 = '0;
        scan_res.slot            = SF'(r_idx);
        scan_res.known           = 1'b1;
        scan_res.needs_keepalive = ev_flags.need;
        scan_res.timed_out       = (rd_recv != '0) && ev_flags.expired;
        scan_res.ping_ms         = rd_ping;
        scan_res.sent_at         = TF'(rd_sent);
        scan_res.received_at     = TF'(rd_recv);
    end

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_interval   = r_interval;
        n_timeout    = r_timeout;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        mem_we       = 1'b0;
        mem_waddr    = p_idx;
        mem_wdata    = {new_ping, new_recv, new_sent};
        mem_re       = 1'b0;
        mem_raddr    = i_in.player[SLOT_BITS-1:0];

        // registers are written only while idle
        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                ktm_pkg::CFG_INTERVAL: n_interval = i_cfg.data;
                ktm_pkg::CFG_TIMEOUT:  n_timeout  = i_cfg.data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // fetch the addressed entry right away
                    mem_re = 1'b1;
                    case (i_in.kind)
                        ktm_pkg::KIND_JOIN, ktm_pkg::KIND_LEAVE, ktm_pkg::KIND_SENT,
                        ktm_pkg::KIND_RESPONSE, ktm_pkg::KIND_UPDATE: begin
                            n_state = S_EXEC;
                        end
                        ktm_pkg::KIND_SCAN: begin
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_SCAN_RD;
                        end
                        default: begin
                            // unused kinds give no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    mem_we      = do_write;
                    n_out       = exec_res;
                    n_out_valid = 1'b1;
                    if (p_in_range) begin
                        n_valid[p_idx] = live_after;
                    end
                    n_state = S_IDLE;
                end
            end

            S_SCAN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_SCAN_EV;
            end

            S_SCAN_EV: begin
                // a hit is held back until the next hit or the end sets last
                if (!scan_hit || !r_pend_valid || out_free) begin
                    if (scan_hit) begin
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out_valid = 1'b1;
                        end
                        n_pend       = scan_res;
                        n_pend_valid = 1'b1;
                    end
                    if (r_idx == SLOT_BITS'(NUM_SLOTS - 1)) begin
                        n_state = S_SCAN_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_END: begin
                if (out_free) begin
                    if (r_pend_valid) begin
                        n_out = r_pend;
                    end else begin
                        // empty scan: a lone end marker
                        n_out = '0;
                    end
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload
        r_out  <= n_out;
        r_pend <= n_pend;
        r_idx  <= n_idx;
        if (in_take) begin
            r_kind   <= i_in.kind;
            r_player <= i_in.player;
            r_stamp  <= i_in.stamp[STAMP_BITS-1:0];
            r_now    <= i_in.now[STAMP_BITS-1:0];
        end
        // control
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_interval   <= ktm_pkg::INTERVAL_RESET;
            r_timeout    <= ktm_pkg::TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_interval   <= n_interval;
            r_timeout    <= n_timeout;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.slot            = r_out.slot;
    assign o_res.known           = r_out.known;
    assign o_res.matched         = r_out.matched;
    assign o_res.needs_keepalive = r_out.needs_keepalive;
    assign o_res.timed_out       = r_out.timed_out;
    assign o_res.ping_ms         = r_out.ping_ms;
    assign o_res.sent_at         = r_out.sent_at;
    assign o_res.received_at     = r_out.received_at;
    assign o_res.last            = r_out.last;

endmodule

// ===== hdl/ktm_ram.sv =====
// ----------------------------------------------------------------------------
// ktm_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ktm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ktm_eval.sv =====
// ----------------------------------------------------------------------------
// ktm_eval
// age tests of one slot: keepalive due and receive timeout, modulo 2^TIME_BITS
// ----------------------------------------------------------------------------
module ktm_eval #(
    parameter int TIME_BITS  = ktm_pkg::TIME_BITS_DEFAULT,
    parameter int STAMP_BITS = ktm_pkg::TIME_FIELD_BITS
) (
    input  logic [STAMP_BITS-1:0]        i_now,
    input  logic [STAMP_BITS-1:0]        i_sent,
    input  logic [STAMP_BITS-1:0]        i_recv,
    input  logic [ktm_pkg::CFG_BITS-1:0] i_interval,
    input  logic [ktm_pkg::CFG_BITS-1:0] i_timeout,
    output ktm_pkg::t_flags              o_flags
);

    logic [TIME_BITS-1:0] since_sent;
    logic [TIME_BITS-1:0] since_recv;

    // wraps at the time width
    assign since_sent = TIME_BITS'(i_now) - TIME_BITS'(i_sent);
    assign since_recv = TIME_BITS'(i_now) - TIME_BITS'(i_recv);

    assign o_flags.need    = (since_sent >= TIME_BITS'(i_interval));
    assign o_flags.expired = (since_recv >= TIME_BITS'(i_timeout));

endmodule
